// ===== rtl/ogc_pkg.sv =====
package ogc_pkg;

  // Operation codes carried in the func field of a request.
  typedef enum logic [1:0] {
    FUNC_PLACE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_t;

  // Cell content that marks an empty cell (-1 as a 16-bit value).
  localparam logic [15:0] CELL_EMPTY = 16'hFFFF;

  localparam int CELL_W = 16;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [14:0]        particle_id;
  } req_t;

  typedef struct packed {
    logic signed [15:0] occupant;
    logic               collision;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
  } rsp_t;

endpackage

// ===== rtl/ogc_ram.sv =====
module ogc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ogc_clear.sv =====
module ogc_clear #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);

  // Walks every address once after reset so that each cell can be written empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      if (addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      addr <= addr + AW'(1);
    end
  end

endmodule

// ===== rtl/toroidal_occupancy_grid_collide.sv =====
// Channel  | Handshake                      | Payload
// request  | req_valid in, req_stall out    | req (req_t): func, x_coord, y_coord, particle_id
// response | rsp_valid out, rsp_stall in    | rsp (rsp_t): occupant, collision, cell_x, cell_y
//
// One request is taken per cycle while req_stall is low; it passes through the cell stage
// and then the output register. The rate is set by the single read-modify-write of the
// grid memory, whose registered read and later write are bridged by a forwarding register.
// After reset a clearing pass writes all GRID_WIDTH * GRID_HEIGHT cells (65536 by default)
// empty, one per cycle; req_stall is high throughout.
// A stalled response holds in the output register; the cell stage behind it keeps its
// request, so at most two requests are in flight and, outside the clearing pass, req_stall rises only when both wait.
module toroidal_occupancy_grid_collide
  import ogc_pkg::*;
#(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Grid sizes must be powers of two, which the block does not check; wrapping a
  // coordinate keeps its low bits, the true non-negative remainder for every signed input value.
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;

  logic              clr_busy;
  logic [AW-1:0]     clr_addr;

  logic              req_acc;
  logic [XW-1:0]     req_cx;
  logic [YW-1:0]     req_cy;
  logic [AW-1:0]     req_addr;
  logic [XW+7:0]     req_cx_wide;
  logic [YW+7:0]     req_cy_wide;

  // Cell stage: the request whose cell is being read from memory.
  logic              s1_valid;
  logic [1:0]        s1_func;
  logic [AW-1:0]     s1_addr;
  logic [14:0]       s1_pid;
  logic [7:0]        s1_cell_x;
  logic [7:0]        s1_cell_y;
  logic              s1_fwd;
  logic [CELL_W-1:0] s1_fwd_data;

  logic              out_free;
  logic              s1_adv;
  logic [CELL_W-1:0] ram_rdata;
  logic [CELL_W-1:0] prev;
  logic [CELL_W-1:0] cell_next;
  logic              cell_we;
  logic              hit;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;

  ogc_clear #(
    .DEPTH (DEPTH)
  ) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  // The response register frees when empty or when its response is taken; the cell
  // stage moves into it then, and only then does its write reach the memory.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_adv    = s1_valid && out_free;
  assign req_stall = clr_busy || (s1_valid && !out_free);
  assign req_acc   = req_valid && !req_stall;

  assign req_cx      = req.x_coord[XW-1:0];
  assign req_cy      = req.y_coord[YW-1:0];
  assign req_addr    = {req_cx, req_cy};
  assign req_cx_wide = {8'd0, req_cx};
  assign req_cy_wide = {8'd0, req_cy};

  // The cell was written at the same edge at which this request read it when the
  // request before it addressed the same cell; the forwarded value is the current one.
  assign prev = s1_fwd ? s1_fwd_data : ram_rdata;

  always_comb begin
    cell_next = prev;
    cell_we   = 1'b0;
    hit       = 1'b0;
    unique case (func_t'(s1_func))
      FUNC_PLACE: begin
        cell_next = {1'b0, s1_pid};
        cell_we   = 1'b1;
        hit       = (prev != CELL_EMPTY) && (prev != {1'b0, s1_pid});
      end
      FUNC_CLEAR: begin
        cell_next = CELL_EMPTY;
        cell_we   = 1'b1;
      end
      FUNC_READ, FUNC_RSVD: begin
        cell_next = prev;
      end
      default: begin
        cell_next = prev;
      end
    endcase
  end

  // The clearing pass owns the write port; no request is in flight while it runs.
  assign ram_we    = clr_busy || (s1_adv && cell_we);
  assign ram_waddr = clr_busy ? clr_addr : s1_addr;
  assign ram_wdata = clr_busy ? CELL_EMPTY : cell_next;

  ogc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req_acc),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_func     <= req.func;
      s1_addr     <= req_addr;
      s1_pid      <= req.particle_id;
      s1_cell_x   <= req_cx_wide[7:0];
      s1_cell_y   <= req_cy_wide[7:0];
      s1_fwd      <= s1_adv && (s1_addr == req_addr);
      s1_fwd_data <= cell_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.occupant  <= prev;
      rsp.collision <= hit;
      rsp.cell_x    <= s1_cell_x;
      rsp.cell_y    <= s1_cell_y;
    end
  end

endmodule

// ===== rtl/ogc_check.sv =====
module ogc_check
  import ogc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled response stays offered and unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed or was dropped");

  // Right after reset the grid is being cleared: nothing is taken and nothing is shown.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> req_stall && !rsp_valid)
    else $error("request taken or response shown during clearing pass");

  // A cell holds either a particle number or the empty mark.
  a_occupant_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.occupant[15] |-> rsp.occupant == CELL_EMPTY)
    else $error("occupant is neither empty nor a particle number");

  // A collision always names a real previous occupant.
  a_collision_occupied: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.collision |-> !rsp.occupant[15])
    else $error("collision reported on an empty cell");

endmodule

bind toroidal_occupancy_grid_collide ogc_check u_ogc_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
